@@ design/bounded_array_list_engine_macros.svh @@
// Assertion macros for the bounded array list engine checker.
// Depends on signals named clk and arst_n in the scope of each use.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BLE_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/ble_pkg.sv @@
// Package for the bounded array list engine: sizes, operation codes,
// request, response and record types. No dependencies.
`timescale 1ns / 1ps

package ble_pkg;

	localparam int CAPACITY = 64;
	localparam int PAYLOAD_BITS = 32;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int COUNT_W = 7;
	localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	typedef enum logic [2:0] {
		OP_PUSH_BACK,
		OP_PUSH_FRONT,
		OP_INSERT_SORTED,
		OP_POP_BACK,
		OP_POP_FRONT,
		OP_REMOVE_KEY,
		OP_READ_POS,
		OP_FIND_KEY
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT_UP,
		ST_SHIFT_DN,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] key;
		logic [31:0]        payload;
		logic [6:0]         position;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic signed [31:0] key_out;
		logic [31:0]        payload_out;
		logic [6:0]         count;
		logic               full_res;
		logic               empty_res;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0]      key;
		logic [PAYLOAD_BITS-1:0] payload;
	} rec_t;

endpackage

@@ design/bounded_array_list_engine.sv @@
// Pop back, a push into a full list, a pop from an empty one and a read at a bad position go
// straight to the result; a read or a push back makes a single memory access; pop front, find,
// push front, key removal and sorted insert search or shift the list, one memory entry a cycle.
// One item is in work at a time; the next can be taken the cycle after its result enters the
// output register. Reset clears the count and control, not the memory.
`timescale 1ns / 1ps

module bounded_array_list_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  ble_pkg::req_t req,
	input  logic          req_valid,
	output logic          req_stall,
	output ble_pkg::rsp_t rsp,
	output logic          rsp_valid,
	input  logic          rsp_stall
);
	import ble_pkg::*;

	rsp_t             ctrl_rsp;
	logic             ctrl_rsp_valid, rsp_take;
	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	rec_t             mem_wdata, mem_rdata;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	ble_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (ctrl_rsp),
		.rsp_valid (ctrl_rsp_valid),
		.rsp_take  (rsp_take),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ble_ram #(
		.WIDTH ($bits(rec_t)),
		.DEPTH (CAPACITY),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign rsp_take = ctrl_rsp_valid && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_take) begin
			rsp_q <= ctrl_rsp;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

@@ design/ble_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module ble_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/ble_ctrl.sv @@
// Sequencer of the bounded array list engine: searches and shifts the
// record memory one entry a cycle and builds the response. Uses ble_pkg.
`timescale 1ns / 1ps

module ble_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ble_pkg::req_t                 req,
	input  logic                          req_valid,
	output logic                          req_stall,
	output ble_pkg::rsp_t                 rsp,
	output logic                          rsp_valid,
	input  logic                          rsp_take,
	output logic                          mem_we,
	output logic [ble_pkg::IDX_W-1:0]     mem_waddr,
	output ble_pkg::rec_t                 mem_wdata,
	output logic                          mem_re,
	output logic [ble_pkg::IDX_W-1:0]     mem_raddr,
	input  ble_pkg::rec_t                 mem_rdata
);
	import ble_pkg::*;

	state_t                  state_q, state_d;
	op_t                     op_q;
	logic signed [31:0]      key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [CNT_W-1:0]        cnt_q, ptr_q, last_q, rem_q, at_q;
	logic                    pend_q;
	logic                    res_ok_q;
	logic signed [31:0]      res_key_q;
	logic [PAYLOAD_BITS-1:0] res_pay_q;

	logic             take, full, empty, pos_ok, match, hit, more;
	logic [CMP_W-1:0] pos_w;

	assign take   = req_valid && (state_q == ST_IDLE);
	assign full   = (cnt_q == CNT_W'(CAPACITY));
	assign empty  = (cnt_q == '0);
	assign pos_w  = CMP_W'(req.position);
	assign pos_ok = (pos_w != '0) && (pos_w <= CMP_W'(cnt_q));
	assign match  = (op_q == OP_INSERT_SORTED) ? !(mem_rdata.key < key_q)
		: (mem_rdata.key == key_q);
	assign hit    = pend_q && match;
	assign more   = (ptr_q < cnt_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					case (req.op)
						OP_PUSH_BACK, OP_PUSH_FRONT: state_d = full ? ST_DONE : ST_SHIFT_UP;
						OP_INSERT_SORTED: state_d = full ? ST_DONE : ST_SEARCH;
						OP_POP_BACK: state_d = ST_DONE;
						OP_POP_FRONT: state_d = empty ? ST_DONE : ST_SHIFT_DN;
						OP_REMOVE_KEY, OP_FIND_KEY: state_d = ST_SEARCH;
						OP_READ_POS: state_d = pos_ok ? ST_READ : ST_DONE;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_SEARCH: begin
				if (hit || !more) begin
					case (op_q)
						OP_INSERT_SORTED: state_d = ST_SHIFT_UP;
						OP_REMOVE_KEY: state_d = hit ? ST_SHIFT_DN : ST_DONE;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_SHIFT_UP, ST_SHIFT_DN: begin
				if (rem_q == '0 && !pend_q) begin
					state_d = ST_DONE;
				end
			end
			ST_READ: state_d = ST_DONE;
			ST_DONE: begin
				if (rsp_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != ST_IDLE);
		rsp_valid = (state_q == ST_DONE);
		mem_re    = 1'b0;
		mem_raddr = ptr_q[IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = at_q[IDX_W-1:0];
		mem_wdata = mem_rdata;
		case (state_q)
			ST_IDLE: begin
				mem_re    = take && (req.op == OP_READ_POS) && pos_ok;
				mem_raddr = IDX_W'(pos_w - CMP_W'(1));
			end
			ST_SEARCH: mem_re = !hit && more;
			ST_SHIFT_UP: begin
				mem_re = (rem_q != '0);
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = IDX_W'(last_q + CNT_W'(1));
				end else if (rem_q == '0) begin
					mem_we    = 1'b1;
					mem_wdata = '{key: key_q, payload: pay_q};
				end
			end
			ST_SHIFT_DN: begin
				mem_re = (rem_q != '0);
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = IDX_W'(last_q - CNT_W'(1));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						op_q      <= req.op;
						key_q     <= req.key;
						pay_q     <= PAYLOAD_BITS'(req.payload);
						res_ok_q  <= 1'b0;
						res_key_q <= '0;
						res_pay_q <= '0;
						pend_q    <= 1'b0;
						case (req.op)
							OP_PUSH_BACK: begin
								at_q  <= cnt_q;
								rem_q <= '0;
								ptr_q <= cnt_q - CNT_W'(1);
							end
							OP_PUSH_FRONT: begin
								at_q  <= '0;
								rem_q <= cnt_q;
								ptr_q <= cnt_q - CNT_W'(1);
							end
							OP_POP_BACK: begin
								if (!empty) begin
									cnt_q    <= cnt_q - CNT_W'(1);
									res_ok_q <= 1'b1;
								end
							end
							OP_POP_FRONT: begin
								ptr_q <= CNT_W'(1);
								rem_q <= cnt_q - CNT_W'(1);
							end
							default: ptr_q <= '0;
						endcase
					end
				end
				ST_SEARCH: begin
					if (hit) begin
						pend_q <= 1'b0;
						at_q   <= last_q;
						if (op_q == OP_INSERT_SORTED) begin
							rem_q <= cnt_q - last_q;
							ptr_q <= cnt_q - CNT_W'(1);
						end else if (op_q == OP_REMOVE_KEY) begin
							rem_q <= cnt_q - last_q - CNT_W'(1);
							ptr_q <= last_q + CNT_W'(1);
						end else begin
							res_ok_q  <= 1'b1;
							res_key_q <= mem_rdata.key;
							res_pay_q <= mem_rdata.payload;
						end
					end else if (more) begin
						last_q <= ptr_q;
						ptr_q  <= ptr_q + CNT_W'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						at_q   <= cnt_q;
						rem_q  <= '0;
					end
				end
				ST_SHIFT_UP, ST_SHIFT_DN: begin
					if (rem_q != '0) begin
						last_q <= ptr_q;
						ptr_q  <= (state_q == ST_SHIFT_UP) ? ptr_q - CNT_W'(1)
							: ptr_q + CNT_W'(1);
						rem_q  <= rem_q - CNT_W'(1);
						pend_q <= 1'b1;
					end else if (pend_q) begin
						pend_q <= 1'b0;
					end else begin
						res_ok_q <= 1'b1;
						cnt_q    <= (state_q == ST_SHIFT_UP) ? cnt_q + CNT_W'(1)
							: cnt_q - CNT_W'(1);
					end
				end
				ST_READ: begin
					res_ok_q  <= 1'b1;
					res_key_q <= mem_rdata.key;
					res_pay_q <= mem_rdata.payload;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		rsp.ok          = res_ok_q;
		rsp.key_out     = res_key_q;
		rsp.payload_out = 32'(res_pay_q);
		rsp.count       = COUNT_W'(cnt_q);
		rsp.full_res    = full;
		rsp.empty_res   = empty;
	end

endmodule

@@ design/ble_checker.sv @@
// Port-level checker for the bounded array list engine and its bind.
// Depends on ble_pkg and bounded_array_list_engine_macros.svh.
`timescale 1ns / 1ps
`include "bounded_array_list_engine_macros.svh"

module ble_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input ble_pkg::rsp_t rsp,
	input logic          rsp_valid,
	input logic          rsp_stall
);
	import ble_pkg::*;

	`BLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled beat changed")
	`BLE_ASSERT_IMPLY(a_full_not_empty, rsp_valid && rsp.full_res, !rsp.empty_res, "full and empty together")
	`BLE_ASSERT_IMPLY(a_empty_count, rsp_valid && rsp.empty_res, rsp.count == '0, "empty with nonzero count")
	`BLE_ASSERT_IMPLY(a_fail_zero, rsp_valid && !rsp.ok, rsp.key_out == '0 && rsp.payload_out == '0, "failed beat carries a record")

endmodule

bind bounded_array_list_engine ble_checker u_checker (.*);

@@ test/tb_bounded_array_list_engine.sv @@
// Self-checking testbench for the bounded array list engine: directed and random list
// operations checked against an in-bench model of the list, under varied flow control.
// Depends on ble_pkg and the bounded_array_list_engine RTL.
`timescale 1ns / 1ps

module tb_bounded_array_list_engine;
	import ble_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int ITEMS_PER_PHASE = 475;
	localparam int MODE_SPAN = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	req_t req = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	rsp_t rsp;
	logic rsp_valid;
	logic rsp_stall = 1'b0;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int idle_pct = 0;
	int stall_pct = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	rec_t list_recs[CAPACITY];
	int list_len = 0;
	logic signed [31:0] key_pool[12];

	bounded_array_list_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp(rsp),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int locate_key(logic signed [31:0] k);
		int i;
		i = 0;
		while (i < list_len && list_recs[i].key != k) i++;
		return i;
	endfunction

	function automatic rsp_t predict_list_op(req_t r);
		rsp_t res;
		int at;
		res = '0;
		case (r.op)
			OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT_SORTED: begin
				if (list_len < CAPACITY) begin
					at = 0;
					if (r.op == OP_PUSH_BACK) begin
						at = list_len;
					end else if (r.op == OP_INSERT_SORTED) begin
						while (at < list_len && list_recs[at].key < r.key) at++;
					end
					for (int k = list_len; k > at; k--) list_recs[k] = list_recs[k - 1];
					list_recs[at].key = r.key;
					list_recs[at].payload = PAYLOAD_BITS'(r.payload);
					list_len++;
					res.ok = 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (list_len > 0) begin
					list_len--;
					res.ok = 1'b1;
				end
			end
			OP_POP_FRONT, OP_REMOVE_KEY: begin
				at = (r.op == OP_POP_FRONT) ? 0 : locate_key(r.key);
				if (at < list_len) begin
					for (int k = at; k + 1 < list_len; k++) list_recs[k] = list_recs[k + 1];
					list_len--;
					res.ok = 1'b1;
				end
			end
			OP_READ_POS, OP_FIND_KEY: begin
				at = (r.op == OP_READ_POS) ? int'(r.position) - 1 : locate_key(r.key);
				if (at >= 0 && at < list_len) begin
					res.key_out = list_recs[at].key;
					res.payload_out = 32'(list_recs[at].payload);
					res.ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.count = 7'(list_len);
		res.full_res = (list_len == CAPACITY);
		res.empty_res = (list_len == 0);
		return res;
	endfunction

	function automatic void add_item(op_t op, logic signed [31:0] key, logic [31:0] payload,
			logic [6:0] position);
		req_t r;
		r.op = op;
		r.key = key;
		r.payload = payload;
		r.position = position;
		pending_reqs.push_back(r);
	endfunction

	function automatic logic signed [31:0] pick_key();
		if ($urandom_range(0, 99) < 60) return key_pool[$urandom_range(0, 11)];
		return $urandom;
	endfunction

	function automatic req_t random_item(bit filling);
		req_t r;
		int roll;
		roll = $urandom_range(0, 99);
		if (filling) begin
			r.op = (roll < 75) ? op_t'($urandom_range(OP_PUSH_BACK, OP_INSERT_SORTED))
				: op_t'($urandom_range(OP_POP_BACK, OP_FIND_KEY));
		end else if (roll < 75) begin
			r.op = op_t'($urandom_range(OP_POP_BACK, OP_REMOVE_KEY));
		end else if ($urandom_range(0, 1)) begin
			r.op = op_t'($urandom_range(OP_PUSH_BACK, OP_INSERT_SORTED));
		end else begin
			r.op = $urandom_range(0, 1) ? OP_READ_POS : OP_FIND_KEY;
		end
		r.key = pick_key();
		r.payload = $urandom;
		r.position = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, CAPACITY + 2))
			: 7'($urandom_range(0, 127));
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall) expected_rsps.push_back(predict_list_op(req));
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					$error("unexpected result beat: 0x%0h", rsp);
					mismatch_count++;
				end else begin
					want = expected_rsps.pop_front();
					check_field("ok", want.ok, rsp.ok);
					check_field("key_out", want.key_out, rsp.key_out);
					check_field("payload_out", want.payload_out, rsp.payload_out);
					check_field("count", want.count, rsp.count);
					check_field("full_res", want.full_res, rsp.full_res);
					check_field("empty_res", want.empty_res, rsp.empty_res);
				end
			end
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("bounded_array_list_engine test failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int produced;
		produced = 0;
		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7fff_ffff;
		key_pool[2] = 0;
		key_pool[3] = -1;
		key_pool[4] = 1;
		for (int i = 5; i < 12; i++) key_pool[i] = $urandom;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_item(OP_POP_BACK, 0, 0, 0);
		add_item(OP_POP_FRONT, 0, 0, 0);
		add_item(OP_REMOVE_KEY, 0, 0, 0);
		add_item(OP_FIND_KEY, 0, 0, 0);
		add_item(OP_READ_POS, 0, 0, 0);
		add_item(OP_READ_POS, 0, 0, 1);
		add_item(OP_PUSH_BACK, 32'sh8000_0000, 32'h0000_0000, 0);
		add_item(OP_PUSH_BACK, 32'sh7fff_ffff, 32'hffff_ffff, 7'h7f);
		add_item(OP_PUSH_FRONT, -1, 32'ha5a5_a5a5, 0);
		add_item(OP_INSERT_SORTED, 0, 32'h1111_1111, 0);
		add_item(OP_INSERT_SORTED, 0, 32'h2222_2222, 0);
		add_item(OP_INSERT_SORTED, 32'sh8000_0000, 32'h5a5a_5a5a, 0);
		add_item(OP_INSERT_SORTED, 32'sh7fff_ffff, 32'h3333_3333, 0);
		add_item(OP_READ_POS, 0, 0, 1);
		add_item(OP_READ_POS, 0, 0, 7);
		add_item(OP_READ_POS, 0, 0, 8);
		add_item(OP_READ_POS, 0, 0, 7'h7f);
		add_item(OP_FIND_KEY, 0, 0, 0);
		add_item(OP_FIND_KEY, 12345, 0, 0);
		add_item(OP_REMOVE_KEY, 0, 0, 0);
		add_item(OP_REMOVE_KEY, 99, 0, 0);
		add_item(OP_FIND_KEY, 0, 0, 0);
		add_item(OP_POP_FRONT, 0, 0, 0);
		add_item(OP_POP_BACK, 0, 0, 0);

		for (int phase = 0; phase < 4; phase++) begin
			@(negedge clk);
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 46;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 46;
				end
				default: begin
					idle_pct = 7;
					stall_pct = 7;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pending_reqs.push_back(random_item(((produced / MODE_SPAN) % 2) == 0));
				produced++;
			end
			while (pending_reqs.size() != 0) @(negedge clk);
		end

		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("bounded_array_list_engine test passed");
		end else begin
			$display("bounded_array_list_engine test failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/ble_pkg.sv
design/ble_ram.sv
design/ble_ctrl.sv
design/bounded_array_list_engine.sv
design/ble_checker.sv
test/tb_bounded_array_list_engine.sv
